// File: rtl/txtcon_pkg.sv
// shared constants, types and helpers for the text console cell engine
package txtcon_pkg;

  // store geometry
  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;

  // counts are 8 bit wide (1..128 after saturation)
  localparam logic [7:0] MAX_ROWS_CNT  = 8'(MAX_ROWS);
  localparam logic [7:0] MAX_COLS_CNT  = 8'(MAX_COLS);
  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [7:0] RESET_ROWS    = 8'd60;

  // byte codes
  localparam logic [7:0] BYTE_NL   = 8'h0A;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_ZERO = 8'h30;

  // colours
  localparam logic [2:0] COLOUR_DEFAULT = 3'd7;
  localparam logic [7:0] COLOUR_LIMIT   = 8'd8;

  // item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // one stored cell, char in the low bits
  typedef struct packed {
    logic [2:0] colour;
    logic [7:0] char_code;
  } cell_t;

  localparam cell_t CELL_BLANK = '{colour: COLOUR_DEFAULT, char_code: 8'h00};

  // write request into the cell memory
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } mem_wr_t;

  // one result item, last field in the low bits
  typedef struct packed {
    logic             scrolled;
    logic [2:0]       current_colour;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_column;
    logic [2:0]       cell_colour;
    logic [7:0]       cell_char;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

  // zero acts as one, large values saturate at the limit
  function automatic logic [7:0] eff_count(input logic [7:0] v, input logic [7:0] limit);
    logic [7:0] r;
    r = v;
    if (v == 8'd0) begin
      r = 8'd1;
    end else if (v > limit) begin
      r = limit;
    end
    return r;
  endfunction

endpackage

// File: rtl/txtcon_cell_ram.sv
// cell memory: one write port, one read port with registered read data
module txtcon_cell_ram (
  input  logic                              clk,
  input  txtcon_pkg::mem_wr_t               wr,
  input  logic [txtcon_pkg::ADDR_W-1:0]     raddr,
  output txtcon_pkg::cell_t                 rdata
);

  txtcon_pkg::cell_t mem [txtcon_pkg::CELLS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/txtcon_out_reg.sv
// result output register toward the master-side stream
module txtcon_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  txtcon_pkg::result_t           in_res,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [txtcon_pkg::OUT_W-1:0]  m_tdata
);

  txtcon_pkg::result_t res;

  assign in_ready = !m_tvalid || m_tready;
  assign m_tdata  = {{(txtcon_pkg::OUT_W - txtcon_pkg::RESULT_W){1'b0}}, res};

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= in_res;
    end
  end

endmodule

// File: rtl/txtcon_ctrl.sv
// sequencer: cursor, colour, escape state, scroll and clear sweeps over the cell memory
module txtcon_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last,
  input  logic [txtcon_pkg::ROW_W-1:0]      in_rrow,
  input  logic [txtcon_pkg::COL_W-1:0]      in_rcol,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [7:0]                        cfg_data,
  output txtcon_pkg::mem_wr_t               mem_wr,
  output logic [txtcon_pkg::ADDR_W-1:0]     mem_raddr,
  input  txtcon_pkg::cell_t                 mem_rdata,
  output logic                              res_valid,
  input  logic                              res_ready,
  output txtcon_pkg::result_t               res
);

  localparam int ROW_W  = txtcon_pkg::ROW_W;
  localparam int COL_W  = txtcon_pkg::COL_W;
  localparam int ADDR_W = txtcon_pkg::ADDR_W;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SCR  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state;
  logic [7:0]        cols;
  logic [7:0]        rows;
  logic [COL_W-1:0]  ccol;
  logic [ROW_W-1:0]  crow;
  logic [2:0]        fg;
  logic              esc;
  logic [ADDR_W-1:0] clr_cnt;
  logic              clr_emit;
  logic [7:0]        srow;
  logic [COL_W-1:0]  scol;
  logic              pw_valid;
  logic [ADDR_W-1:0] pw_addr;
  logic              pw_blank;
  logic [7:0]        res_char;
  logic [2:0]        res_col;
  logic              res_scr;

  // decoded byte action
  logic              accept;
  logic              wr_store;
  logic              nl;
  logic              scroll;
  logic [7:0]        col_t;
  logic [7:0]        row_t;
  logic [7:0]        col_next;
  logic [7:0]        row_next;
  logic [2:0]        fg_next;
  logic              esc_next;
  logic [7:0]        esc_val;

  // scroll sweep
  logic              op_blank;
  logic              last_col;
  logic [7:0]        cfg_eff_cols;
  logic [7:0]        cfg_eff_rows;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign esc_val  = in_byte - txtcon_pkg::BYTE_ZERO;

  // next cursor and colour for a write beat
  always_comb begin
    wr_store = 1'b0;
    nl       = 1'b0;
    scroll   = 1'b0;
    col_t    = 8'd0;
    row_t    = 8'd0;
    col_next = {1'b0, ccol};
    row_next = {1'b0, crow};
    fg_next  = fg;
    esc_next = esc;
    if (esc) begin
      esc_next = 1'b0;
      fg_next  = (esc_val >= txtcon_pkg::COLOUR_LIMIT) ? txtcon_pkg::COLOUR_DEFAULT
                                                        : esc_val[2:0];
    end else begin
      case (in_byte)
        txtcon_pkg::BYTE_NL: begin
          nl = 1'b1;
        end
        txtcon_pkg::BYTE_TAB: begin
          col_t = {({1'b0, ccol[COL_W-1:3]} + 5'd1), 3'b000};
          if (col_t >= cols) begin
            nl = 1'b1;
          end else begin
            col_next = col_t;
          end
        end
        txtcon_pkg::BYTE_ESC: begin
          if (!in_last) begin
            esc_next = 1'b1;
          end
        end
        txtcon_pkg::BYTE_CR: begin
        end
        default: begin
          wr_store = 1'b1;
          col_t    = {1'b0, ccol} + 8'd1;
          if (col_t >= cols) begin
            nl = 1'b1;
          end else begin
            col_next = col_t;
          end
        end
      endcase
    end
    if (nl) begin
      col_next = 8'd0;
      row_t    = {1'b0, crow} + 8'd1;
      if (row_t >= rows) begin
        row_next = rows - 8'd1;
        scroll   = 1'b1;
      end else begin
        row_next = row_t;
      end
    end
  end

  // scroll step decode
  assign op_blank = (srow == rows);
  assign last_col = ({1'b0, scol} == (cols - 8'd1));

  // read address: scroll source during a scroll, otherwise the read beat cell
  assign mem_raddr = (state == ST_SCR) ? {srow[ROW_W-1:0], scol} : {in_rrow, in_rcol};

  // memory write select
  always_comb begin
    mem_wr = '0;
    if (pw_valid) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = pw_addr;
      mem_wr.data = pw_blank ? txtcon_pkg::cell_t'{colour: fg, char_code: 8'h00} : mem_rdata;
    end else if (state == ST_CLR) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clr_cnt;
      mem_wr.data = txtcon_pkg::CELL_BLANK;
    end else if (accept && (in_mode == txtcon_pkg::MODE_WRITE) && wr_store) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = {crow, ccol};
      mem_wr.data = '{colour: fg, char_code: in_byte};
    end
  end

  // result offered to the output register
  assign res_valid          = (state == ST_EMIT);
  assign res.cell_char      = res_char;
  assign res.cell_colour    = res_col;
  assign res.cursor_column  = ccol;
  assign res.cursor_row     = crow;
  assign res.current_colour = fg;
  assign res.scrolled       = res_scr;

  assign cfg_eff_cols = txtcon_pkg::eff_count(cfg_data, txtcon_pkg::MAX_COLS_CNT);
  assign cfg_eff_rows = txtcon_pkg::eff_count(cfg_data, txtcon_pkg::MAX_ROWS_CNT);

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      cols     <= txtcon_pkg::RESET_COLUMNS;
      rows     <= txtcon_pkg::RESET_ROWS;
      ccol     <= '0;
      crow     <= '0;
      fg       <= txtcon_pkg::COLOUR_DEFAULT;
      esc      <= 1'b0;
      clr_cnt  <= '0;
      clr_emit <= 1'b0;
      srow     <= 8'd0;
      scol     <= '0;
      pw_valid <= 1'b0;
    end else begin
      pw_valid <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == {ADDR_W{1'b1}}) begin
            state    <= clr_emit ? ST_EMIT : ST_IDLE;
            clr_emit <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (in_mode)
              txtcon_pkg::MODE_WRITE: begin
                ccol <= col_next[COL_W-1:0];
                crow <= row_next[ROW_W-1:0];
                fg   <= fg_next;
                esc  <= esc_next;
                if (scroll) begin
                  srow  <= 8'd1;
                  scol  <= '0;
                  state <= ST_SCR;
                end else begin
                  state <= ST_EMIT;
                end
              end
              txtcon_pkg::MODE_READ: begin
                state <= ST_RD;
              end
              txtcon_pkg::MODE_CLEAR: begin
                ccol     <= '0;
                crow     <= '0;
                fg       <= txtcon_pkg::COLOUR_DEFAULT;
                esc      <= 1'b0;
                clr_cnt  <= '0;
                clr_emit <= 1'b1;
                state    <= ST_CLR;
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_RD: begin
          state <= ST_EMIT;
        end
        ST_SCR: begin
          pw_valid <= 1'b1;
          if (last_col) begin
            scol <= '0;
            if (op_blank) begin
              state <= ST_EMIT;
            end else begin
              srow <= srow + 8'd1;
            end
          end else begin
            scol <= scol + COL_W'(1);
          end
        end
        ST_EMIT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // register writes, taken in any state unless a beat is accepted in the same cycle
      if (cfg_we && !accept) begin
        if (cfg_index == txtcon_pkg::CFG_COLUMNS) begin
          cols <= cfg_eff_cols;
          if ({1'b0, ccol} >= cfg_eff_cols) begin
            ccol <= COL_W'(cfg_eff_cols - 8'd1);
          end
        end else begin
          rows <= cfg_eff_rows;
          if ({1'b0, crow} >= cfg_eff_rows) begin
            crow <= ROW_W'(cfg_eff_rows - 8'd1);
          end
        end
      end
    end
  end

  // scroll write pipeline: read data arrives in the cycle after the read
  always_ff @(posedge clk) begin
    pw_addr  <= {ROW_W'(srow - 8'd1), scol};
    pw_blank <= op_blank;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      res_char <= mem_rdata.char_code;
      res_col  <= mem_rdata.colour;
      res_scr  <= 1'b0;
    end else if (accept) begin
      res_char <= 8'd0;
      res_col  <= 3'd0;
      res_scr  <= (in_mode == txtcon_pkg::MODE_WRITE) && scroll;
    end
  end

endmodule

// File: rtl/text_console_cell_engine_top.sv
// top level of the text console cell engine
// a write or control beat goes to EMIT after acceptance, a read beat through RD first
// a beat that scrolls first sweeps rows*columns cells, one cell copied or blanked per cycle
// a clear beat sweeps all 16384 cells, one per cycle, before its result
// reset is synchronous: the same sweep over all 16384 cells runs first and s_tready stays low meanwhile
// one beat is in work at a time: a new beat is taken only once the last result is passed on
module text_console_cell_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], read_row[14:8], read_column[21:15], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        s_tlast,   // last_in_write
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_char, cell_colour, cursor_column, cursor_row,
                                 // current_colour, scrolled, zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  txtcon_pkg::mem_wr_t                mem_wr;
  logic [txtcon_pkg::ADDR_W-1:0]      mem_raddr;
  txtcon_pkg::cell_t                  mem_rdata;
  logic                               res_valid;
  logic                               res_ready;
  txtcon_pkg::result_t                res;

  // sequencer
  txtcon_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_byte   (s_tdata[7:0]),
    .in_last   (s_tlast),
    .in_rrow   (s_tdata[14:8]),
    .in_rcol   (s_tdata[21:15]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // cell memory
  txtcon_cell_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  txtcon_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_res   (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: verif/text_console_cell_engine_top_tb.sv
`timescale 1ns / 100ps
// self-checking stream testbench for the text console cell engine, with a cycle-free console model
module text_console_cell_engine_top_tb;

  localparam int STALL_LIMIT = 100000;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASES      = 30;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // one console request as it travels on the slave side
  typedef struct {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       last_in_write;
    logic [6:0] read_row;
    logic [6:0] read_column;
  } con_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // data_byte, read_row, read_column, zero pad
  logic [1:0]  s_tuser = '0;   // mode
  logic        s_tlast = 1'b0; // last_in_write
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // cell_char, cell_colour, cursor_column, cursor_row,
                               // current_colour, scrolled, zero pad
  logic        cfg_we = 1'b0;
  logic        cfg_index = txtcon_pkg::CFG_COLUMNS;
  logic [7:0]  cfg_data = '0;

  text_console_cell_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // console shadow state
  logic [7:0] shadow_char   [txtcon_pkg::CELLS];
  logic [2:0] shadow_colour [txtcon_pkg::CELLS];
  int         cur_col;
  int         cur_row;
  logic [2:0] fg_colour;
  bit         esc_waiting;
  logic [7:0] columns_reg;
  logic [7:0] rows_reg;

  con_item_t           pending_beats[$];
  txtcon_pkg::result_t expected_results[$];
  int                  queued_beats;
  int                  accepted_beats;
  int                  checked_results;
  int                  failures;
  int                  idle_pct;
  bit                  in_beat_taken;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // zero acts as one, large counts saturate
  function automatic int in_use(input logic [7:0] v, input int lim);
    if (v == 8'd0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  task automatic blank_console;
    for (int i = 0; i < txtcon_pkg::CELLS; i++) begin
      shadow_char[i]   = 8'h00;
      shadow_colour[i] = txtcon_pkg::COLOUR_DEFAULT;
    end
  endtask

  // start of next row, scrolling the in-use area at the bottom
  task automatic advance_row(output bit scr);
    int cols;
    int rows;
    cols = in_use(columns_reg, txtcon_pkg::MAX_COLS);
    rows = in_use(rows_reg, txtcon_pkg::MAX_ROWS);
    scr = 1'b0;
    cur_col = 0;
    cur_row++;
    if (cur_row >= rows) begin
      cur_row = rows - 1;
      scr = 1'b1;
      for (int r = 1; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          shadow_char[(r - 1) * txtcon_pkg::MAX_COLS + c] =
            shadow_char[r * txtcon_pkg::MAX_COLS + c];
          shadow_colour[(r - 1) * txtcon_pkg::MAX_COLS + c] =
            shadow_colour[r * txtcon_pkg::MAX_COLS + c];
        end
      end
      for (int c = 0; c < cols; c++) begin
        shadow_char[(rows - 1) * txtcon_pkg::MAX_COLS + c]   = 8'h00;
        shadow_colour[(rows - 1) * txtcon_pkg::MAX_COLS + c] = fg_colour;
      end
    end
  endtask

  // one byte of a console write
  task automatic console_byte(input logic [7:0] b, input logic last, output bit scr);
    int cols;
    int v;
    int pos;
    cols = in_use(columns_reg, txtcon_pkg::MAX_COLS);
    scr = 1'b0;
    if (esc_waiting) begin
      esc_waiting = 1'b0;
      v = int'(8'(b - txtcon_pkg::BYTE_ZERO));
      fg_colour = (v >= 8) ? txtcon_pkg::COLOUR_DEFAULT : 3'(v);
    end else if (b == txtcon_pkg::BYTE_NL) begin
      advance_row(scr);
    end else if (b == txtcon_pkg::BYTE_TAB) begin
      cur_col = (cur_col / 8 + 1) * 8;
      if (cur_col >= cols) advance_row(scr);
    end else if (b == txtcon_pkg::BYTE_ESC) begin
      if (!last) esc_waiting = 1'b1;
    end else if (b != txtcon_pkg::BYTE_CR) begin
      pos = cur_row * txtcon_pkg::MAX_COLS + cur_col;
      shadow_char[pos]   = b;
      shadow_colour[pos] = fg_colour;
      cur_col++;
      if (cur_col >= cols) advance_row(scr);
    end
  endtask

  // expected result of one accepted beat
  task automatic predict_beat(input con_item_t it, output txtcon_pkg::result_t res);
    bit scr;
    int pos;
    scr = 1'b0;
    res = '0;
    case (it.mode)
      txtcon_pkg::MODE_WRITE: begin
        console_byte(it.data_byte, it.last_in_write, scr);
      end
      txtcon_pkg::MODE_READ: begin
        pos = int'(it.read_row) * txtcon_pkg::MAX_COLS + int'(it.read_column);
        res.cell_char   = shadow_char[pos];
        res.cell_colour = shadow_colour[pos];
      end
      txtcon_pkg::MODE_CLEAR: begin
        blank_console();
        cur_col     = 0;
        cur_row     = 0;
        fg_colour   = txtcon_pkg::COLOUR_DEFAULT;
        esc_waiting = 1'b0;
      end
      default: begin
      end
    endcase
    res.cursor_column  = txtcon_pkg::COL_W'(cur_col);
    res.cursor_row     = txtcon_pkg::ROW_W'(cur_row);
    res.current_colour = fg_colour;
    res.scrolled       = scr;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  function automatic con_item_t beat_of(input logic [1:0] mode, input logic [7:0] b,
                                        input logic last, input int row, input int col);
    con_item_t it;
    it.mode          = mode;
    it.data_byte     = b;
    it.last_in_write = last;
    it.read_row      = 7'(row);
    it.read_column   = 7'(col);
    return it;
  endfunction

  task automatic send(input con_item_t it);
    pending_beats.push_back(it);
    queued_beats++;
  endtask

  // wait until every queued beat is taken and answered
  task automatic drain;
    @(negedge clk);
    while (accepted_beats != queued_beats || checked_results != queued_beats) @(negedge clk);
  endtask

  // register write, only while the console is idle
  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == txtcon_pkg::CFG_COLUMNS) columns_reg = val;
    else rows_reg = val;
    if (cur_col >= in_use(columns_reg, txtcon_pkg::MAX_COLS))
      cur_col = in_use(columns_reg, txtcon_pkg::MAX_COLS) - 1;
    if (cur_row >= in_use(rows_reg, txtcon_pkg::MAX_ROWS))
      cur_row = in_use(rows_reg, txtcon_pkg::MAX_ROWS) - 1;
  endtask

  // mostly plausible console traffic, some noise
  task automatic push_random(input int cols, input int rows);
    con_item_t it;
    int pick;
    int rr;
    int rc;
    it = beat_of(txtcon_pkg::MODE_WRITE, 8'($urandom), ($urandom_range(0, 7) == 0),
                 $urandom_range(0, 127), $urandom_range(0, 127));
    pick = $urandom_range(0, 999);
    if (pick < 450) begin
      it.data_byte = 8'($urandom_range(32, 126));
    end else if (pick < 560) begin
      it.data_byte = txtcon_pkg::BYTE_NL;
    end else if (pick < 630) begin
      it.data_byte = txtcon_pkg::BYTE_TAB;
    end else if (pick < 650) begin
      it.data_byte = txtcon_pkg::BYTE_CR;
    end else if (pick < 740) begin
      // colour escape, sometimes cut off at the end of a write
      it.data_byte     = txtcon_pkg::BYTE_ESC;
      it.last_in_write = ($urandom_range(0, 9) == 0);
      send(it);
      it = beat_of(txtcon_pkg::MODE_WRITE, 8'(txtcon_pkg::BYTE_ZERO + $urandom_range(0, 9)),
                   ($urandom_range(0, 7) == 0), $urandom_range(0, 127), $urandom_range(0, 127));
      if ($urandom_range(0, 3) == 0) it.data_byte = 8'($urandom);
    end else if (pick < 930) begin
      it.mode = txtcon_pkg::MODE_READ;
      if ($urandom_range(0, 3) != 0) begin
        rr = $urandom_range(0, rows);
        rc = $urandom_range(0, cols);
        it.read_row    = 7'((rr > 127) ? 127 : rr);
        it.read_column = 7'((rc > 127) ? 127 : rc);
      end
    end else if (pick < 990) begin
      it.data_byte = 8'($urandom);
    end else if (pick < 998) begin
      it.mode = MODE_SPARE;
    end else begin
      it.mode = txtcon_pkg::MODE_CLEAR;
    end
    send(it);
  endtask

  // slave-side driver and master-side ready, changed at the falling edge
  always @(negedge clk) begin : drive_proc
    con_item_t nxt;
    if (!s_tvalid || in_beat_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = pending_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, nxt.read_column, nxt.read_row, nxt.data_byte};
        s_tuser  <= nxt.mode;
        s_tlast  <= nxt.last_in_write;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // accepted beats feed the model, results are checked in order
  always @(posedge clk) begin : monitor_proc
    con_item_t           seen;
    txtcon_pkg::result_t want;
    txtcon_pkg::result_t got;
    in_beat_taken = s_tvalid && s_tready && !rst;
    if (in_beat_taken) begin
      seen.data_byte     = s_tdata[7:0];
      seen.read_row      = s_tdata[14:8];
      seen.read_column   = s_tdata[21:15];
      seen.mode          = s_tuser;
      seen.last_in_write = s_tlast;
      predict_beat(seen, want);
      expected_results.push_back(want);
      accepted_beats++;
    end
    if (m_tvalid && m_tready && !rst) begin
      got = txtcon_pkg::result_t'(m_tdata[txtcon_pkg::RESULT_W-1:0]);
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat expected none actual %h", $time, got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        compare_field("cell_char", want.cell_char, got.cell_char);
        compare_field("cell_colour", want.cell_colour, got.cell_colour);
        compare_field("cursor_column", want.cursor_column, got.cursor_column);
        compare_field("cursor_row", want.cursor_row, got.cursor_row);
        compare_field("current_colour", want.current_colour, got.current_colour);
        compare_field("scrolled", want.scrolled, got.scrolled);
        checked_results++;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin : watchdog_proc
    int quiet_cycles;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t no beat moved for %0d cycles", $time, quiet_cycles);
      $display("text_console_cell_engine_top_tb failed");
      $finish;
    end
  end

  // stimulus sequence
  initial begin : stim_proc
    int start;
    int beats;
    int cols;
    int rows;
    logic [7:0] cols_val;
    logic [7:0] rows_val;
    blank_console();
    cur_col     = 0;
    cur_row     = 0;
    fg_colour   = txtcon_pkg::COLOUR_DEFAULT;
    esc_waiting = 1'b0;
    columns_reg = txtcon_pkg::RESET_COLUMNS;
    rows_reg    = txtcon_pkg::RESET_ROWS;
    idle_pct    = 34;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset geometry
    send(beat_of(txtcon_pkg::MODE_WRITE, "H", 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, 8'h00, 1'b0, 127, 127));
    send(beat_of(txtcon_pkg::MODE_WRITE, 8'hFF, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_CR, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_TAB, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_ESC, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, "3", 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, "x", 1'b0, 0, 0));
    // escape followed by bytes that land at 8 or above
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_ESC, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, 8'hFF, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_ESC, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, "/", 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_ESC, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, "8", 1'b0, 0, 0));
    // escape that ends a write is dropped
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_ESC, 1'b1, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, "y", 1'b1, 0, 0));
    // read keeps a pending escape
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_ESC, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_READ, 8'h00, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, "5", 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_NL, 1'b0, 0, 0));
    send(beat_of(MODE_SPARE, 8'hFF, 1'b1, 127, 127));
    send(beat_of(txtcon_pkg::MODE_READ, 8'hFF, 1'b1, 127, 127));
    send(beat_of(txtcon_pkg::MODE_READ, 8'h00, 1'b0, 0, 8));
    // clear cancels a pending escape
    send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_ESC, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_CLEAR, 8'h00, 1'b0, 0, 0));
    send(beat_of(txtcon_pkg::MODE_READ, 8'h00, 1'b0, 0, 0));

    // geometry phases: extremes first, then mostly small random ones
    for (int phase = 0; phase < PHASES; phase++) begin
      cols_val = 8'($urandom_range(1, 24));
      rows_val = 8'($urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) cols_val = 8'($urandom_range(128, 255));
      if ($urandom_range(0, 9) == 0) rows_val = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd200;
      beats    = 40;
      idle_pct = 34;
      case (phase)
        0: begin cols_val = 8'd0;   rows_val = 8'd0;   beats = 30; end
        1: begin cols_val = 8'd255; rows_val = 8'd255; beats = 40; end
        2: begin cols_val = 8'd1;   rows_val = 8'd128; beats = 60; end
        3: begin cols_val = 8'd128; rows_val = 8'd1;   beats = 60; end
        4: begin cols_val = 8'd129; rows_val = 8'd2;   beats = 60; end
        5: begin cols_val = 8'd128; rows_val = 8'd128; beats = 12; end
        10: begin beats = 120; idle_pct = 0; end
        default: begin
        end
      endcase
      drain();
      write_reg(txtcon_pkg::CFG_COLUMNS, cols_val);
      write_reg(txtcon_pkg::CFG_ROWS, rows_val);
      cols = in_use(cols_val, txtcon_pkg::MAX_COLS);
      rows = in_use(rows_val, txtcon_pkg::MAX_ROWS);
      if (phase == 5) begin
        // full screen: clear, then run the cursor down to the row just above the bottom one
        send(beat_of(txtcon_pkg::MODE_CLEAR, 8'($urandom), 1'b0, 0, 0));
        repeat (126) send(beat_of(txtcon_pkg::MODE_WRITE, txtcon_pkg::BYTE_NL, 1'b0, 0, 0));
      end
      start = queued_beats;
      while (queued_beats < start + beats) push_random(cols, rows);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("text_console_cell_engine_top_tb passed");
    end else begin
      $display("text_console_cell_engine_top_tb failed");
    end
    $finish;
  end

endmodule
